### rtl/core/pidc_pkg.sv
// pidc_pkg: shared widths, codes, payload types and saturation helper
// for the pid controller step unit. No dependencies.

package pidc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int ERR_W       = 17;
   localparam int GAIN_W      = 24;
   localparam int DECAY_W     = 18;
   localparam int WORD_W      = 32;
   localparam int CSR_INDEX_W = 3;

   // operation codes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DERIV_DECAY   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_MIN       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_MAX       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEG_MIN     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEG_MAX     = 3'd7;

   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic                        operation;
      logic signed [SAMPLE_W-1:0]  setpoint;
      logic signed [SAMPLE_W-1:0]  measurement;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] drive;
      logic                     out_clamped;
      logic                     integ_clamped;
   } rsp_type;

   typedef struct packed {
      logic        [GAIN_W-1:0]  prop_gain;
      logic        [GAIN_W-1:0]  integral_gain;
      logic        [GAIN_W-1:0]  deriv_gain;
      logic signed [DECAY_W-1:0] deriv_decay;
      logic signed [WORD_W-1:0]  out_min;
      logic signed [WORD_W-1:0]  out_max;
      logic signed [WORD_W-1:0]  integ_min;
      logic signed [WORD_W-1:0]  integ_max;
   } cfg_type;

   // saturate a sign-extended value to a signed 32 bit word
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] x);
      logic signed [WORD_W-1:0] r;
      if (x > 64'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (x < 64'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = x[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/pidc_ifs.sv
// pidc_ifs: valid/ready channel interfaces for request, result and
// register write beats. Depends on pidc_pkg for field widths.

interface pidc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic signed [pidc_pkg::SAMPLE_W-1:0] setpoint;
   logic signed [pidc_pkg::SAMPLE_W-1:0] measurement;
   modport source (output valid, operation, setpoint, measurement, input ready);
   modport sink   (input valid, operation, setpoint, measurement, output ready);
endinterface

interface pidc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pidc_pkg::WORD_W-1:0] drive;
   logic                               out_clamped;
   logic                               integ_clamped;
   modport source (output valid, drive, out_clamped, integ_clamped, input ready);
   modport sink   (input valid, drive, out_clamped, integ_clamped, output ready);
endinterface

interface pidc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pidc_pkg::CSR_INDEX_W-1:0]    index;
   logic [pidc_pkg::WORD_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/pidc_csr.sv
// pidc_csr: configuration register bank for gains, decay and limits.
// Depends on pidc_pkg and pidc_csr_if.

module pidc_csr (
   input  logic                clock,
   input  logic                reset,
   pidc_csr_if.sink            csr_bus,
   output pidc_pkg::cfg_type   cfg
);

   pidc_pkg::cfg_type cfg_ff;
   pidc_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_bus.ready = 1'b1;

   // decode one write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            pidc_pkg::REG_PROP_GAIN:     cfg_in.prop_gain     = csr_bus.data[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::REG_INTEGRAL_GAIN: cfg_in.integral_gain = csr_bus.data[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::REG_DERIV_GAIN:    cfg_in.deriv_gain    = csr_bus.data[pidc_pkg::GAIN_W-1:0];
            pidc_pkg::REG_DERIV_DECAY:   cfg_in.deriv_decay   = csr_bus.data[pidc_pkg::DECAY_W-1:0];
            pidc_pkg::REG_OUT_MIN:       cfg_in.out_min       = csr_bus.data;
            pidc_pkg::REG_OUT_MAX:       cfg_in.out_max       = csr_bus.data;
            pidc_pkg::REG_INTEG_MIN:     cfg_in.integ_min     = csr_bus.data;
            pidc_pkg::REG_INTEG_MAX:     cfg_in.integ_max     = csr_bus.data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= '0;
         cfg_ff.integral_gain <= '0;
         cfg_ff.deriv_gain    <= '0;
         cfg_ff.deriv_decay   <= '0;
         cfg_ff.out_min       <= pidc_pkg::WORD_MIN;
         cfg_ff.out_max       <= pidc_pkg::WORD_MAX;
         cfg_ff.integ_min     <= pidc_pkg::WORD_MIN;
         cfg_ff.integ_max     <= pidc_pkg::WORD_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/pidc_core.sv
// pidc_core: controller state and the combinational update datapath
// (proportional, trapezoidal integrator, filtered derivative, clamps).
// Depends on pidc_pkg.

module pidc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  pidc_pkg::req_type   item,
   input  pidc_pkg::cfg_type   cfg,
   output pidc_pkg::rsp_type   result
);

   // controller state
   logic signed [pidc_pkg::WORD_W-1:0]   integ_acc_ff,    integ_acc_in;
   logic signed [pidc_pkg::WORD_W-1:0]   deriv_acc_ff,    deriv_acc_in;
   logic signed [pidc_pkg::ERR_W-1:0]    last_error_ff,   last_error_in;
   logic signed [pidc_pkg::SAMPLE_W-1:0] last_measure_ff, last_measure_in;

   logic signed [pidc_pkg::ERR_W-1:0]   err;
   logic signed [pidc_pkg::ERR_W:0]     err_sum;
   logic signed [pidc_pkg::ERR_W-1:0]   meas_diff;
   logic signed [41:0]                  prod_p;
   logic signed [42:0]                  prod_i;
   logic signed [49:0]                  prod_d;
   logic signed [41:0]                  prod_k;
   logic signed [33:0]                  decayed;
   logic signed [34:0]                  deriv_raw;
   logic signed [32:0]                  integ_raw;
   logic signed [33:0]                  sum_raw;
   logic signed [pidc_pkg::WORD_W-1:0]  p_term, i_inc, integ_sat, d_kick, deriv_new;
   logic signed [pidc_pkg::WORD_W-1:0]  integ_new, sum_sat, drive;
   logic                                integ_hi, integ_lo, out_hi, out_lo;

   // error terms
   assign err       = 17'(item.setpoint) - 17'(item.measurement);
   assign err_sum   = 18'(err) + 18'(last_error_ff);
   assign meas_diff = 17'(item.measurement) - 17'(last_measure_ff);

   // gain products, exact
   assign prod_p = $signed({1'b0, cfg.prop_gain}) * err;
   assign prod_i = $signed({1'b0, cfg.integral_gain}) * err_sum;
   assign prod_d = cfg.deriv_decay * deriv_acc_ff;
   assign prod_k = $signed({1'b0, cfg.deriv_gain}) * meas_diff;

   assign p_term = pidc_pkg::sat_word(64'(prod_p));
   assign i_inc  = pidc_pkg::sat_word(64'(prod_i));
   assign d_kick = pidc_pkg::sat_word(64'(prod_k));

   // integrator: saturating add, then clamp with upper limit first
   assign integ_raw = 33'(integ_acc_ff) + 33'(i_inc);
   assign integ_sat = pidc_pkg::sat_word(64'(integ_raw));
   assign integ_hi  = integ_sat > cfg.integ_max;
   assign integ_lo  = integ_sat < cfg.integ_min;
   assign integ_new = integ_hi ? cfg.integ_max : (integ_lo ? cfg.integ_min : integ_sat);

   // derivative: floor of decay product, minus measurement kick
   assign decayed   = prod_d[49:16];
   assign deriv_raw = 35'(decayed) - 35'(d_kick);
   assign deriv_new = pidc_pkg::sat_word(64'(deriv_raw));

   // three-term sum and output clamp
   assign sum_raw = 34'(p_term) + 34'(integ_new) + 34'(deriv_new);
   assign sum_sat = pidc_pkg::sat_word(64'(sum_raw));
   assign out_hi  = sum_sat > cfg.out_max;
   assign out_lo  = sum_sat < cfg.out_min;
   assign drive   = out_hi ? cfg.out_max : (out_lo ? cfg.out_min : sum_sat);

   // result and next state
   always_comb begin
      integ_acc_in    = integ_acc_ff;
      deriv_acc_in    = deriv_acc_ff;
      last_error_in   = last_error_ff;
      last_measure_in = last_measure_ff;
      if (item.operation == pidc_pkg::OP_CLEAR) begin
         result.drive         = '0;
         result.out_clamped   = 1'b0;
         result.integ_clamped = 1'b0;
         if (fire) begin
            integ_acc_in    = '0;
            deriv_acc_in    = '0;
            last_error_in   = '0;
            last_measure_in = '0;
         end
      end else begin
         result.drive         = drive;
         result.out_clamped   = out_hi | out_lo;
         result.integ_clamped = integ_hi | integ_lo;
         if (fire) begin
            integ_acc_in    = integ_new;
            deriv_acc_in    = deriv_new;
            last_error_in   = err;
            last_measure_in = item.measurement;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_acc_ff    <= '0;
         deriv_acc_ff    <= '0;
         last_error_ff   <= '0;
         last_measure_ff <= '0;
      end else begin
         integ_acc_ff    <= integ_acc_in;
         deriv_acc_ff    <= deriv_acc_in;
         last_error_ff   <= last_error_in;
         last_measure_ff <= last_measure_in;
      end
   end

endmodule

### rtl/core/pid_controller_step_unit.sv
// Top level of the pid controller step unit: input register, update
// datapath, result register. Depends on pidc_pkg, pidc_ifs, pidc_csr, pidc_core.

// The unit takes one request beat per cycle unless a stalled result backs
// up the input register, and returns exactly one result beat per request,
// in order. A request waits in the input register until its result can be
// taken, while the datapath forms error, the proportional term, the
// trapezoidal integrator and the filtered derivative, updates the stored
// state and writes the clamped drive into the result register. The update,
// four multiplies (three gains, one decay), saturating adds and two clamps,
// is combinational: one item per clock unless results stall. A waiting
// result still lets one request in. The user must write gains and limits
// through the register port only with no request in flight; not enforced.

module pid_controller_step_unit (
   input  logic         clock,
   input  logic         reset,
   pidc_req_if.sink     req_bus,
   pidc_rsp_if.source   rsp_bus,
   pidc_csr_if.sink     csr_bus
);

   pidc_pkg::cfg_type cfg;
   pidc_pkg::rsp_type core_result;
   pidc_pkg::req_type in_item_ff, in_item_in;
   pidc_pkg::rsp_type out_item_ff, out_item_in;
   logic              in_valid_ff, in_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              core_fire;
   logic              req_take;

   pidc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   pidc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (core_fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // handshake control
   assign core_fire     = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || core_fire;
   assign req_take      = req_bus.valid && req_bus.ready;

   // next values of the input and result registers
   always_comb begin
      in_item_in   = in_item_ff;
      out_item_in  = out_item_ff;
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
      if (req_take) begin
         in_item_in.operation   = req_bus.operation;
         in_item_in.setpoint    = req_bus.setpoint;
         in_item_in.measurement = req_bus.measurement;
      end
      if (core_fire) begin
         out_valid_in = 1'b1;
         out_item_in  = core_result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // result beat
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.drive         = out_item_ff.drive;
   assign rsp_bus.out_clamped   = out_item_ff.out_clamped;
   assign rsp_bus.integ_clamped = out_item_ff.integ_clamped;

`ifndef NO_ASSERTIONS
   // a taken request is in the input register next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("taken request beat lost");

   // a stalled result keeps the pending request in the input register
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_bus.ready |=> in_valid_ff)
      else $error("pending request dropped under stall");

   // a processed clear returns zero with no limit flags
   assert property (@(posedge clock) disable iff (reset)
      core_fire && in_item_ff.operation == pidc_pkg::OP_CLEAR |=>
         out_valid_ff && out_item_ff.drive == '0 &&
         !out_item_ff.out_clamped && !out_item_ff.integ_clamped)
      else $error("clear result not zero");
`endif

endmodule
